### hw/rtl/assert_macros.svh
// Assertion macros used by the frame checker RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

### hw/rtl/cfc_pkg.sv
// Shared types, constants and the byte-wide CRC-32 function of the frame checker
package cfc_pkg;

    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_MAGIC   = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_TOO_LONG    = 3'd3,
        ST_BAD_CRC     = 3'd4
    } t_status;

    typedef struct packed {
        logic [31:0] expected_magic;
        logic [31:0] expected_version;
        logic [31:0] max_payload_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        is_verdict;
        t_status     status;
        logic [7:0]  message_type;
        logic [31:0] payload_length;
    } t_result;

    // Fold one byte into the reflected CRC register, one bit per step
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

### hw/rtl/cfc_in_reg.sv
// Input register of the frame checker: holds one word until the parser takes it
module cfc_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data,
    output logic       o_stall,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_data
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_data;
    logic       take;

    // Take a new word when the register is empty or drains this cycle
    assign o_stall = r_valid && !i_advance;
    assign take    = i_valid && !o_stall;
    assign n_valid = take || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### hw/rtl/cfc_frame_fsm.sv
// Frame parser: header phases, CRC accumulation and verdict generation
`include "assert_macros.svh"
module cfc_frame_fsm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cfc_pkg::t_cfg   i_cfg,
    input  logic            i_step,
    input  logic [7:0]      i_data,
    output logic            o_res_valid,
    output cfc_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_VERSION = 3'd1,
        PH_TYPE    = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC     = 3'd5
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_idx, n_idx;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_crc, n_crc;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_len, n_len;
    logic [31:0] r_rem, n_rem;

    logic [31:0] shifted;
    logic [31:0] crc_next;
    logic        full;
    logic        hunt;
    cfc_pkg::t_result res;
    logic        res_valid;

    assign shifted  = {i_data, r_shift[31:8]};
    assign crc_next = cfc_pkg::crc_byte(r_crc, i_data);
    assign full     = (r_idx == 2'd3);

    // Work out the next state and any result for the word at the input
    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_shift   = r_shift;
        n_crc     = r_crc;
        n_type    = r_type;
        n_len     = r_len;
        n_rem     = r_rem;
        hunt      = 1'b0;
        res_valid = 1'b0;
        res       = '{payload_byte: 8'd0, is_verdict: 1'b1, status: cfc_pkg::ST_OK,
                      message_type: 8'd0, payload_length: 32'd0};
        case (r_phase)
            PH_MAGIC: begin
                n_shift = shifted;
                n_idx   = 2'(r_idx + 2'd1);
                if (full) begin
                    if (shifted != i_cfg.expected_magic) begin
                        res_valid  = 1'b1;
                        res.status = cfc_pkg::ST_BAD_MAGIC;
                        hunt       = 1'b1;
                    end else begin
                        n_phase = PH_VERSION;
                        n_crc   = cfc_pkg::CRC_ALL_ONES;
                    end
                end
            end
            PH_VERSION: begin
                n_crc   = crc_next;
                n_shift = shifted;
                n_idx   = 2'(r_idx + 2'd1);
                if (full) begin
                    if (shifted != i_cfg.expected_version) begin
                        res_valid  = 1'b1;
                        res.status = cfc_pkg::ST_BAD_VERSION;
                        hunt       = 1'b1;
                    end else begin
                        n_phase = PH_TYPE;
                    end
                end
            end
            PH_TYPE: begin
                n_crc   = crc_next;
                n_type  = i_data;
                n_phase = PH_LENGTH;
                n_idx   = 2'd0;
            end
            PH_LENGTH: begin
                n_crc   = crc_next;
                n_shift = shifted;
                n_idx   = 2'(r_idx + 2'd1);
                if (full) begin
                    n_len = shifted;
                    if (shifted > i_cfg.max_payload_length) begin
                        res_valid          = 1'b1;
                        res.status         = cfc_pkg::ST_TOO_LONG;
                        res.message_type   = r_type;
                        res.payload_length = shifted;
                        hunt               = 1'b1;
                    end else begin
                        n_rem   = shifted;
                        n_phase = (shifted == 32'd0) ? PH_CRC : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_crc = crc_next;
                n_rem = r_rem - 32'd1;
                if (r_rem == 32'd1) begin
                    n_phase = PH_CRC;
                    n_idx   = 2'd0;
                end
                res_valid        = 1'b1;
                res.payload_byte = i_data;
                res.is_verdict   = 1'b0;
            end
            PH_CRC: begin
                n_shift = shifted;
                n_idx   = 2'(r_idx + 2'd1);
                if (full) begin
                    res_valid          = 1'b1;
                    res.status         = (shifted == (r_crc ^ cfc_pkg::CRC_ALL_ONES))
                                         ? cfc_pkg::ST_OK : cfc_pkg::ST_BAD_CRC;
                    res.message_type   = r_type;
                    res.payload_length = r_len;
                    hunt               = 1'b1;
                end
            end
            default: begin
                // Unknown phase: restart the hunt and take this word as the first magic byte
                n_phase = PH_MAGIC;
                n_idx   = 2'd1;
                n_shift = {i_data, 24'd0};
                n_crc   = cfc_pkg::CRC_ALL_ONES;
                n_type  = 8'd0;
                n_len   = 32'd0;
                n_rem   = 32'd0;
            end
        endcase
        // After a verdict, clear the frame state and hunt for the next header
        if (hunt) begin
            n_phase = PH_MAGIC;
            n_idx   = 2'd0;
            n_shift = 32'd0;
            n_crc   = cfc_pkg::CRC_ALL_ONES;
            n_type  = 8'd0;
            n_len   = 32'd0;
            n_rem   = 32'd0;
        end
    end

    // Hold the parser state; advance only when a word is stepped in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_idx   <= 2'd0;
            r_shift <= 32'd0;
            r_crc   <= cfc_pkg::CRC_ALL_ONES;
            r_type  <= 8'd0;
            r_len   <= 32'd0;
            r_rem   <= 32'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_shift <= n_shift;
            r_crc   <= n_crc;
            r_type  <= n_type;
            r_len   <= n_len;
            r_rem   <= n_rem;
        end
    end

    assign o_res_valid = res_valid;
    assign o_res       = res;

    `ASSERT_CLK(a_verdict_restarts, i_step && res_valid && res.is_verdict |=> r_phase == PH_MAGIC, "verdict did not restart the hunt")
    `ASSERT_CLK(a_payload_in_phase, res_valid && !res.is_verdict |-> r_phase == PH_PAYLOAD, "payload word outside the payload phase")
    `ASSERT_NEVER(a_payload_count, r_phase == PH_PAYLOAD && r_rem == 32'd0, "payload phase with nothing left")
    `ASSERT_CLK(a_field_aligned, r_phase == PH_TYPE || r_phase == PH_PAYLOAD |-> r_idx == 2'd0, "field byte count out of step")

endmodule

### hw/rtl/cfc_out_reg.sv
// Result register of the frame checker: holds one result until the sink takes it
module cfc_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cfc_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_stall,
    output cfc_pkg::t_result o_res
);

    logic             r_valid;
    logic             n_valid;
    cfc_pkg::t_result r_res;

    // Room for a new result when empty or being taken this cycle
    assign o_free  = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### hw/rtl/crc32_frame_checker.sv
// Top level of the length-prefixed frame checker with CRC-32
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_data_byte
//   result    out        o_out_valid / i_out_stall o_payload_byte, o_is_verdict,
//                                                  o_status, o_message_type,
//                                                  o_payload_length
//   config    in         i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// One word per clock is sustained while the result side does not stall; a result passes
// through the input register and then the result register around the parser step.
// Words that give no result never wait for the result register.
// Reset is synchronous, active low: configuration clears to zero, the parser hunts.
// A stall on the result side holds the result and, once the input register holds
// a word that gives a result, stalls the input side.
module crc32_frame_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_payload_byte,
    output logic                          o_is_verdict,
    output logic [2:0]                    o_status,
    output logic [7:0]                    o_message_type,
    output logic [31:0]                   o_payload_length,
    input  logic                          i_cfg_wr_en,
    input  logic [cfc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    cfc_pkg::t_cfg    r_cfg;
    logic             in_valid;
    logic [7:0]       in_data;
    logic             step;
    logic             res_valid;
    cfc_pkg::t_result res;
    logic             out_free;
    cfc_pkg::t_result out_res;

    // Write configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                cfc_pkg::CFG_MAGIC:   r_cfg.expected_magic     <= i_cfg_data;
                cfc_pkg::CFG_VERSION: r_cfg.expected_version   <= i_cfg_data;
                cfc_pkg::CFG_MAX_LEN: r_cfg.max_payload_length <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cfc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_data    (i_data_byte),
        .o_stall   (o_in_stall),
        .i_advance (step),
        .o_valid   (in_valid),
        .o_data    (in_data)
    );

    // Advance a word unless it has a result and the result register is full
    assign step = in_valid && (!res_valid || out_free);

    cfc_frame_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_step      (step),
        .i_data      (in_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cfc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    assign o_payload_byte   = out_res.payload_byte;
    assign o_is_verdict     = out_res.is_verdict;
    assign o_status         = out_res.status;
    assign o_message_type   = out_res.message_type;
    assign o_payload_length = out_res.payload_length;

endmodule
